>>> rtl/integer_to_text_formatter_unit_defines.svh
// assertion macros for the formatter rtl
// no dependencies; files that assert include this header
`ifndef INTEGER_TO_TEXT_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ITF_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("formatter check failed");
// next-cycle implication, sampled on clk, off during reset
`define ITF_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("formatter check failed");
`else
`define ITF_ASSERT_IMPL(lbl, a, b)
`define ITF_ASSERT_NEXT(lbl, a, b)
`endif
`endif

>>> rtl/itf_pkg.sv
// shared types, codes and character constants of the integer formatter
// no dependencies
package itf_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 7;

    localparam logic [OPCODE_W-1:0] OP_BINARY  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DECIMAL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_HEX     = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

    localparam logic [3:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [OPCODE_W-1:0]       opcode;
        logic                      pad;
    } req_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
    } rsp_item_t;

    // status of the binary to bcd converter
    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

    function automatic logic [CHAR_W-1:0] char_of_digit(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN)
        begin
            c = CH_ZERO + {3'b000, d};
        end
        else
        begin
            c = CH_LOW_A + {3'b000, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

>>> rtl/itf_bcd_conv.sv
// bit-serial binary to bcd converter (shift and add-3), one bit per cycle
// depends on itf_pkg
module itf_bcd_conv #(
    parameter int NUMBER_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [NUMBER_BITS-1:0]                 mag,
    output logic [((NUMBER_BITS*3)/10+1)*4-1:0]    bcd,
    output itf_pkg::conv_status_t                  status
);

    localparam int BCD_DIGITS = (NUMBER_BITS * 3) / 10 + 1;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int CNT_W      = $clog2(NUMBER_BITS + 1);

    logic [NUMBER_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [BCD_W-1:0]       adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next = mag;
            bcd_next = '0;
            cnt_next = CNT_W'(NUMBER_BITS);
        end
        else if (cnt_reg != '0)
        begin
            bcd_next = {adj[BCD_W-2:0], mag_reg[NUMBER_BITS-1]};
            mag_next = {mag_reg[NUMBER_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign bcd         = bcd_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

>>> rtl/integer_to_text_formatter_unit.sv
// top level of the integer to ascii text formatter
// depends on itf_pkg, itf_bcd_conv and integer_to_text_formatter_unit_defines.svh
//
// usage
//   req channel: one beat carries value, opcode (binary, decimal, hex) and pad.
//   rsp channel: one beat per ascii character, most significant first; last
//   marks the final character of a number. an undefined opcode is taken and
//   dropped with no rsp beats.
//   timing: decimal passes through the bit-serial bcd converter, one bit per
//   cycle; binary and hex skip it. emission then sends any prefix characters
//   and steps through each stored digit position (NUMBER_BITS for binary,
//   ceil(NUMBER_BITS/4) for hex, (NUMBER_BITS*3)/10+1 for decimal), leading
//   zeros dropped one a cycle; a character is sent only when the output
//   register is free.
//   req_ready is high only while idle; one number is worked at a time.
//   the next req beat is taken while the final character still sits in the
//   output register.
//   reset: asynchronous, clears the sequencer and the output valid flag.
//   stall: a low rsp_ready holds the output register and freezes character emission; leading zeros are still dropped.
`include "integer_to_text_formatter_unit_defines.svh"

module integer_to_text_formatter_unit #(
    parameter int NUMBER_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  itf_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output itf_pkg::rsp_item_t  rsp
);

    // digit positions for each format
    localparam int BCD_DIGITS = (NUMBER_BITS * 3) / 10 + 1;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int HEX_DIGITS = (NUMBER_BITS + 3) / 4;
    localparam int HEX_W      = HEX_DIGITS * 4;
    // emission shift register holds the widest digit image, msb aligned
    localparam int EW_A       = (BCD_W > HEX_W) ? BCD_W : HEX_W;
    localparam int EW         = (EW_A > NUMBER_BITS) ? EW_A : NUMBER_BITS;
    localparam int REM_W      = $clog2(NUMBER_BITS + 1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [itf_pkg::OPCODE_W-1:0]  op_reg, op_next;
    logic                          pad_reg, pad_next;
    logic                          lead_reg, lead_next;
    logic [1:0]                    pre_reg, pre_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [EW-1:0]                 emit_reg, emit_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    itf_pkg::rsp_item_t            rsp_reg, rsp_next;

    // magnitude of the incoming beat
    logic [NUMBER_BITS-1:0]        raw;
    logic                          neg;
    logic [NUMBER_BITS-1:0]        mag;

    logic                          conv_start;
    logic [BCD_W-1:0]              bcd;
    itf_pkg::conv_status_t         conv_st;

    logic                          slot_free;
    logic                          accept;
    logic [3:0]                    dig;
    logic                          last_dig;
    logic                          skip;
    logic [EW-1:0]                 emit_shifted;

    assign raw = req.value[NUMBER_BITS-1:0];
    assign neg = raw[NUMBER_BITS-1];
    assign mag = neg ? NUMBER_BITS'(~raw + NUMBER_BITS'(1)) : raw;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    assign conv_start = accept && (req.opcode == itf_pkg::OP_DECIMAL);

    itf_bcd_conv #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_bcd_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .mag    (mag),
        .bcd    (bcd),
        .status (conv_st)
    );

    // top digit of the emission register; binary digits are one bit wide
    always_comb
    begin
        if (op_reg == itf_pkg::OP_BINARY)
        begin
            dig          = {3'b000, emit_reg[EW-1]};
            emit_shifted = {emit_reg[EW-2:0], 1'b0};
        end
        else
        begin
            dig          = emit_reg[EW-1 -: 4];
            emit_shifted = {emit_reg[EW-5:0], 4'b0000};
        end
    end

    assign last_dig = (rem_reg == REM_W'(1));
    // leading zeros drop unless padding is on for binary or hex, the final digit always prints
    assign skip = lead_reg && (dig == 4'd0) && !last_dig
                  && !(pad_reg && (op_reg != itf_pkg::OP_DECIMAL));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pad_next       = pad_reg;
        lead_next      = lead_reg;
        pre_next       = pre_reg;
        rem_next       = rem_reg;
        emit_next      = emit_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = req.opcode;
                    pad_next  = req.pad;
                    lead_next = 1'b1;
                    priority if (req.opcode == itf_pkg::OP_BINARY)
                    begin
                        pre_next   = 2'd0;
                        rem_next   = REM_W'(NUMBER_BITS);
                        emit_next  = EW'(mag) << (EW - NUMBER_BITS);
                        state_next = ST_EMIT;
                    end
                    else if (req.opcode == itf_pkg::OP_HEX)
                    begin
                        pre_next   = 2'd2;
                        rem_next   = REM_W'(HEX_DIGITS);
                        emit_next  = EW'(mag) << (EW - HEX_W);
                        state_next = ST_EMIT;
                    end
                    else if (req.opcode == itf_pkg::OP_DECIMAL)
                    begin
                        pre_next   = neg ? 2'd1 : 2'd0;
                        rem_next   = REM_W'(BCD_DIGITS);
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        // undefined opcode: beat dropped
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CONV:
            begin
                if (conv_st.done)
                begin
                    emit_next  = EW'(bcd) << (EW - BCD_W);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (pre_reg != 2'd0)
                begin
                    if (slot_free)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next.last  = 1'b0;
                        priority if (op_reg == itf_pkg::OP_DECIMAL)
                        begin
                            rsp_next.text_char = itf_pkg::CH_MINUS;
                        end
                        else if (pre_reg == 2'd2)
                        begin
                            rsp_next.text_char = itf_pkg::CH_ZERO;
                        end
                        else
                        begin
                            rsp_next.text_char = itf_pkg::CH_X;
                        end
                        pre_next = pre_reg - 2'd1;
                    end
                end
                else if (skip)
                begin
                    emit_next = emit_shifted;
                    rem_next  = rem_reg - REM_W'(1);
                end
                else if (slot_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.text_char = itf_pkg::char_of_digit(dig);
                    rsp_next.last      = last_dig;
                    emit_next          = emit_shifted;
                    rem_next           = rem_reg - REM_W'(1);
                    lead_next          = 1'b0;
                    if (last_dig)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            pre_reg       <= 2'd0;
            rem_reg       <= '0;
            lead_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pre_reg       <= pre_next;
            rem_reg       <= rem_next;
            lead_reg      <= lead_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pad_reg  <= pad_next;
        emit_reg <= emit_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // digits remain to be sent whenever emission runs
    `ITF_ASSERT_IMPL(a_emit_has_digits, (state_reg == ST_EMIT), (rem_reg != '0))
    // the converter only finishes while the sequencer waits on it
    `ITF_ASSERT_IMPL(a_conv_done_in_conv, conv_st.done, (state_reg == ST_CONV))
    // no conversion runs behind an idle sequencer
    `ITF_ASSERT_IMPL(a_idle_conv_quiet, (state_reg == ST_IDLE), !conv_st.busy)
    // a beat marked last ends the number: the sequencer is idle right after
    `ITF_ASSERT_NEXT(a_last_then_idle,
        (state_reg == ST_EMIT) && (pre_reg == 2'd0) && !skip && slot_free && last_dig,
        (state_reg == ST_IDLE) && rsp_valid && rsp.last)

endmodule
